@@ sv/sfm_pkg.sv @@
// Shared types and constants of the subscription feed merge unit.
package sfm_pkg;

  // Field widths fixed by the command and result formats.
  localparam int unsigned USER_W  = 4;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned STAMP_W = 32;

  // Command codes carried on the command field.
  typedef enum logic [1:0] {
    CMD_POST     = 2'd0,
    CMD_FOLLOW   = 2'd1,
    CMD_UNFOLLOW = 2'd2,
    CMD_FEED     = 2'd3
  } cmd_t;

  // One stored post: tweet id and its global sequence stamp.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } post_t;

endpackage

@@ sv/sfm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/subscription_feed_merge_unit.sv @@
// Top level of the subscription feed merge unit: command sequencer, tables and merge scan.
// The unit takes one command beat at a time and is not ready while a command is in work.
// A post reads the user's ring pointers, then writes the post and pointers; follow and
// unfollow read the follow row, then write it back. Out-of-range posts, follows and
// unfollows are dropped. A feed request returns at most FEED_LENGTH tweets; when fewer are
// found, a last scan that finds nothing ends it, and an empty feed gives one empty beat.
// The sequencer waits while the result register is held by out_ready. Each returned tweet
// costs one scan over all users:
// the ring-pointer memory and the post memory are read in a pipeline, one user per cycle, and
// a single stamp comparator keeps the newest candidate. The result register decouples the
// output beat from the sequencer. Tables are reset through per-entry valid bits, so no
// clearing pass is needed after reset. Stored posts are undefined until written and are only
// read while the owner's post count covers the slot.
module subscription_feed_merge_unit #(
  parameter int unsigned NUM_USERS     = 16,
  parameter int unsigned KEEP_PER_USER = 10,
  parameter int unsigned FEED_LENGTH   = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [sfm_pkg::USER_W-1:0]   user,
  input  logic [sfm_pkg::USER_W-1:0]   other_user,
  input  logic [sfm_pkg::ID_W-1:0]     tweet_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sfm_pkg::ID_W-1:0]     feed_tweet,
  output logic                         last,
  output logic                         empty_res
);

  localparam int unsigned UW  = $clog2(NUM_USERS);
  localparam int unsigned IW  = $clog2(NUM_USERS + 1);
  localparam int unsigned SW  = $clog2(KEEP_PER_USER);
  localparam int unsigned CNW = $clog2(KEEP_PER_USER + 1);
  localparam int unsigned PD  = NUM_USERS * KEEP_PER_USER;
  localparam int unsigned PAW = $clog2(PD);
  localparam int unsigned NW  = $clog2(FEED_LENGTH + 1);
  localparam int unsigned MW  = SW + 2 * CNW;
  localparam int unsigned PW  = sfm_pkg::ID_W + sfm_pkg::STAMP_W;

  // Per-user ring pointers: next slot to write, kept posts, posts taken in this merge.
  typedef struct packed {
    logic [SW-1:0]  head;
    logic [CNW-1:0] count;
    logic [CNW-1:0] cursor;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POST,
    S_FOLLOW,
    S_FEED_ROW,
    S_SCAN,
    S_UPDATE,
    S_EMIT_MID,
    S_LOAD,
    S_EMIT_FIN
  } state_t;

  state_t                         state;
  sfm_pkg::cmd_t                  cmd_r;
  logic [UW-1:0]                  user_r;
  logic [UW-1:0]                  oth_r;
  logic [sfm_pkg::ID_W-1:0]       id_r;
  logic [sfm_pkg::STAMP_W-1:0]    seq;
  logic [NUM_USERS-1:0]           row_valid;
  logic [NUM_USERS-1:0]           meta_valid;
  logic [NUM_USERS-1:0]           cursor_valid;
  logic [NUM_USERS-1:0]           follow_row;
  logic [IW-1:0]                  iss;
  logic                           v1;
  logic [UW-1:0]                  u1;
  logic                           v2;
  logic [UW-1:0]                  u2;
  meta_t                          meta2;
  logic                           found;
  logic [UW-1:0]                  best_u;
  meta_t                          best_meta;
  logic [sfm_pkg::ID_W-1:0]       best_id;
  logic [sfm_pkg::STAMP_W-1:0]    best_stamp;
  logic [sfm_pkg::ID_W-1:0]       pend_id;
  logic                           have_pend;
  logic [NW-1:0]                  feed_n;

  // Memory ports.
  logic                 follow_we;
  logic [UW-1:0]        follow_waddr;
  logic [NUM_USERS-1:0] follow_wdata;
  logic [UW-1:0]        follow_raddr;
  logic [NUM_USERS-1:0] follow_rdata;
  logic                 meta_we;
  logic [UW-1:0]        meta_waddr;
  meta_t                meta_wdata;
  logic [UW-1:0]        meta_raddr;
  logic [MW-1:0]        meta_rdata;
  logic                 post_we;
  logic [PAW-1:0]       post_waddr;
  sfm_pkg::post_t       post_wdata;
  logic [PAW-1:0]       post_raddr;
  logic [PW-1:0]        post_rdata;

  // Combinational helpers.
  meta_t                       meta_rd;
  meta_t                       mp;
  meta_t                       m1;
  logic [CNW-1:0]              cur1;
  logic                        elig1;
  logic [CNW:0]                slot_sum;
  logic [SW-1:0]               slot1;
  sfm_pkg::post_t              post_rd;
  logic [sfm_pkg::STAMP_W-1:0] stamp_next;
  logic [SW-1:0]               head_next;
  logic [CNW-1:0]              count_next;
  logic [NUM_USERS-1:0]        row_base;
  logic [NUM_USERS-1:0]        row_mod;
  logic                        user_ok;
  logic                        oth_ok;
  logic                        out_free;
  logic                        emit_now;
  logic                        scan_done;
  meta_t                       best_meta_inc;

  sfm_ram #(.WIDTH(NUM_USERS), .DEPTH(NUM_USERS)) u_follow_ram (
    .clk   (clk),
    .we    (follow_we),
    .waddr (follow_waddr),
    .wdata (follow_wdata),
    .raddr (follow_raddr),
    .rdata (follow_rdata)
  );

  sfm_ram #(.WIDTH(MW), .DEPTH(NUM_USERS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  sfm_ram #(.WIDTH(PW), .DEPTH(PD)) u_post_ram (
    .clk   (clk),
    .we    (post_we),
    .waddr (post_waddr),
    .wdata (post_wdata),
    .raddr (post_raddr),
    .rdata (post_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign emit_now = ((state == S_EMIT_MID) || (state == S_EMIT_FIN)) && out_free;
  assign user_ok  = (32'(user) < 32'(NUM_USERS));
  assign oth_ok   = (32'(other_user) < 32'(NUM_USERS));

  // Read addresses: the incoming user while idle, the scan index while merging.
  assign follow_raddr = UW'(user);
  assign meta_raddr   = (state == S_SCAN) ? UW'(iss) : UW'(user);

  assign meta_rd = meta_t'(meta_rdata);
  assign post_rd = sfm_pkg::post_t'(post_rdata);

  // Post path: pointers of the acting user, reset value while never written.
  assign mp         = meta_valid[user_r] ? meta_rd : '0;
  assign stamp_next = (seq == '1) ? seq : seq + 1'b1;
  assign head_next  = (mp.head == SW'(KEEP_PER_USER - 1)) ? '0 : mp.head + 1'b1;
  assign count_next = (mp.count == CNW'(KEEP_PER_USER)) ? mp.count : mp.count + 1'b1;

  // Follow path: read-modify-write of one row.
  assign row_base = row_valid[user_r] ? follow_rdata : '0;
  always_comb begin
    row_mod        = row_base;
    row_mod[oth_r] = (cmd_r == sfm_pkg::CMD_FOLLOW);
  end

  // Scan stage one: eligibility of the user and the slot of its next-newest post.
  assign m1       = meta_valid[u1] ? meta_rd : '0;
  assign cur1     = cursor_valid[u1] ? m1.cursor : '0;
  assign elig1    = v1 && ((u1 == user_r) || follow_row[u1]) && (m1.count > cur1);
  assign slot_sum = (CNW+1)'(m1.head) + (CNW+1)'(KEEP_PER_USER - 1) - (CNW+1)'(cur1);
  assign slot1    = (slot_sum >= (CNW+1)'(KEEP_PER_USER)) ?
                    SW'(slot_sum - (CNW+1)'(KEEP_PER_USER)) : SW'(slot_sum);
  assign post_raddr = PAW'(u1) * PAW'(KEEP_PER_USER) + PAW'(slot1);

  assign scan_done = (iss == IW'(NUM_USERS)) && !v1 && !v2;

  always_comb begin
    best_meta_inc        = best_meta;
    best_meta_inc.cursor = best_meta.cursor + 1'b1;
  end

  // Memory write ports.
  always_comb begin
    follow_we    = 1'b0;
    follow_waddr = user_r;
    follow_wdata = row_mod;
    meta_we      = 1'b0;
    meta_waddr   = user_r;
    meta_wdata   = '{head: head_next, count: count_next, cursor: mp.cursor};
    post_we      = 1'b0;
    post_waddr   = PAW'(user_r) * PAW'(KEEP_PER_USER) + PAW'(mp.head);
    post_wdata   = '{id: id_r, stamp: stamp_next};
    unique case (state)
      S_POST: begin
        meta_we = 1'b1;
        post_we = 1'b1;
      end
      S_FOLLOW: begin
        follow_we = 1'b1;
      end
      S_UPDATE: begin
        meta_we    = found;
        meta_waddr = best_u;
        meta_wdata = best_meta_inc;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, merge pipeline and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seq          <= '0;
      row_valid    <= '0;
      meta_valid   <= '0;
      cursor_valid <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      found        <= 1'b0;
      have_pend    <= 1'b0;
      feed_n       <= '0;
      iss          <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A taken beat leaves the register unless a new beat replaces it.
      if (out_valid && out_ready && !emit_now) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= sfm_pkg::cmd_t'(command);
            user_r <= UW'(user);
            oth_r  <= UW'(other_user);
            id_r   <= tweet_id;
            unique case (sfm_pkg::cmd_t'(command))
              sfm_pkg::CMD_POST: begin
                state <= user_ok ? S_POST : S_IDLE;
              end
              sfm_pkg::CMD_FOLLOW, sfm_pkg::CMD_UNFOLLOW: begin
                state <= (user_ok && oth_ok) ? S_FOLLOW : S_IDLE;
              end
              sfm_pkg::CMD_FEED: begin
                cursor_valid <= '0;
                have_pend    <= 1'b0;
                feed_n       <= '0;
                state        <= user_ok ? S_FEED_ROW : S_EMIT_FIN;
              end
            endcase
          end
        end
        S_POST: begin
          seq                <= stamp_next;
          meta_valid[user_r] <= 1'b1;
          state              <= S_IDLE;
        end
        S_FOLLOW: begin
          row_valid[user_r] <= 1'b1;
          state             <= S_IDLE;
        end
        S_FEED_ROW: begin
          follow_row <= row_base;
          iss        <= '0;
          v1         <= 1'b0;
          v2         <= 1'b0;
          found      <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          // Stage zero: issue the pointer read of the next user.
          if (iss != IW'(NUM_USERS)) begin
            v1  <= 1'b1;
            u1  <= UW'(iss);
            iss <= iss + 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          // Stage one: issue the post read of an eligible user.
          v2    <= elig1;
          u2    <= u1;
          meta2 <= '{head: m1.head, count: m1.count, cursor: cur1};
          // Stage two: keep the newest stamp; lower users win ties.
          if (v2 && (!found || (post_rd.stamp > best_stamp))) begin
            found      <= 1'b1;
            best_u     <= u2;
            best_meta  <= meta2;
            best_id    <= post_rd.id;
            best_stamp <= post_rd.stamp;
          end
          if (scan_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (found) begin
            cursor_valid[best_u] <= 1'b1;
            state                <= have_pend ? S_EMIT_MID : S_LOAD;
          end else begin
            state <= S_EMIT_FIN;
          end
        end
        S_EMIT_MID: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            feed_tweet <= pend_id;
            last       <= 1'b0;
            empty_res  <= 1'b0;
            state      <= S_LOAD;
          end
        end
        S_LOAD: begin
          pend_id   <= best_id;
          have_pend <= 1'b1;
          feed_n    <= feed_n + 1'b1;
          if (NW'(feed_n + 1'b1) == NW'(FEED_LENGTH)) begin
            state <= S_EMIT_FIN;
          end else begin
            iss   <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_EMIT_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            feed_tweet <= have_pend ? pend_id : '0;
            last       <= 1'b1;
            empty_res  <= !have_pend;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An empty feed beat is always the final beat and carries no tweet.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && (feed_tweet == '0))
    else $error("empty feed beat without last or with a tweet id");

  // A new merge scan only starts while the feed still has room.
  a_feed_room: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> feed_n < NW'(FEED_LENGTH))
    else $error("merge scan running past the feed length");

  // The scan pipeline is drained before the winner is committed.
  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> !v1 && !v2 && (iss == IW'(NUM_USERS)))
    else $error("winner committed with the scan pipeline still busy");

  // A feed command never returns to idle without producing a result beat.
  a_feed_answers: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT_FIN && out_free |=> out_valid && last)
    else $error("final feed beat not presented");
`endif

endmodule

@@ sim/tb_top.sv @@
// Testbench for the subscription feed merge unit: directed table, then random commands.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_USERS     = 16;
  localparam int KEEP_PER_USER = 10;
  localparam int FEED_LENGTH   = 10;
  localparam int RANDOM_ITEMS  = 135;
  localparam int CALM_ITEMS    = 30;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int SCRIPT_ROWS   = 25;
  localparam int USER_W        = sfm_pkg::USER_W;
  localparam int ID_W          = sfm_pkg::ID_W;
  localparam int STAMP_W       = sfm_pkg::STAMP_W;

  // One feed beat as it should leave the unit.
  typedef struct packed {
    logic [ID_W-1:0] tweet;
    logic            last;
    logic            empty;
  } feed_beat_t;

  // One row of the directed script; typed rows carry their single result.
  typedef struct packed {
    sfm_pkg::cmd_t     cmd;
    logic [USER_W-1:0] user;
    logic [USER_W-1:0] peer;
    logic [ID_W-1:0]   tweet;
    logic              typed;
    logic [ID_W-1:0]   want_tweet;
    logic              want_last;
    logic              want_empty;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{sfm_pkg::CMD_FEED,     4'd0,  4'd0,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b1},
    '{sfm_pkg::CMD_FEED,     4'd15, 4'd0,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b1},
    '{sfm_pkg::CMD_POST,     4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_POST,     4'd0,  4'd15, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FOLLOW,   4'd0,  4'd15, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_POST,     4'd15, 4'd0,  16'hA5A5, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_POST,     4'd15, 4'd0,  16'h5A5A, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FOLLOW,   4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_UNFOLLOW, 4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd15, 4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_UNFOLLOW, 4'd0,  4'd15, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_POST,     4'd9,  4'd0,  16'h1234, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd9,  4'd0,  16'h0000, 1'b1, 16'h1234, 1'b1, 1'b0},
    '{sfm_pkg::CMD_FOLLOW,   4'd15, 4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FOLLOW,   4'd15, 4'd9,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd15, 4'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_UNFOLLOW, 4'd15, 4'd9,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd7,  4'd0,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b1},
    '{sfm_pkg::CMD_FOLLOW,   4'd7,  4'd3,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{sfm_pkg::CMD_FEED,     4'd7,  4'd0,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b1}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = sfm_pkg::CMD_POST;
  logic [USER_W-1:0] user = '0;
  logic [USER_W-1:0] other_user = '0;
  logic [ID_W-1:0]   tweet_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   feed_tweet;
  logic              last;
  logic              empty_res;

  // Run control shared between the sender, the receiver and the watchdog.
  logic idle_on = 1'b1;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   error_count = 0;

  // Mirror of the unit's tables.
  logic [STAMP_W-1:0]   stamp_counter;
  logic [NUM_USERS-1:0] follow_rows [NUM_USERS];
  logic [ID_W-1:0]      ring_ids    [NUM_USERS][KEEP_PER_USER];
  logic [STAMP_W-1:0]   ring_stamps [NUM_USERS][KEEP_PER_USER];
  int                   ring_fill   [NUM_USERS];
  int                   ring_next   [NUM_USERS];

  feed_beat_t feed_expected [$];

  subscription_feed_merge_unit #(
    .NUM_USERS     (NUM_USERS),
    .KEEP_PER_USER (KEEP_PER_USER),
    .FEED_LENGTH   (FEED_LENGTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .user       (user),
    .other_user (other_user),
    .tweet_id   (tweet_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .feed_tweet (feed_tweet),
    .last       (last),
    .empty_res  (empty_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $display("MISMATCH at %0t: %s, expected %h, got %h", $realtime, what, want, got);
  endtask

  // Clear the mirrored tables to their state after reset.
  task automatic clear_tables();
    stamp_counter = '0;
    for (int u = 0; u < NUM_USERS; u++) begin
      follow_rows[u] = '0;
      ring_fill[u] = 0;
      ring_next[u] = 0;
      for (int k = 0; k < KEEP_PER_USER; k++) begin
        ring_ids[u][k] = '0;
        ring_stamps[u][k] = '0;
      end
    end
  endtask

  // Apply one accepted command to the mirror; a feed merges the newest posts
  // across the followed users and queues its beats when asked to.
  task automatic apply_command(input sfm_pkg::cmd_t cmd, input logic [USER_W-1:0] u,
                               input logic [USER_W-1:0] peer, input logic [ID_W-1:0] id,
                               input bit record);
    int           taken [NUM_USERS];
    int           count;
    int           best;
    int           slot;
    bit           found;
    logic [STAMP_W-1:0] best_stamp;
    logic [STAMP_W-1:0] s;
    feed_beat_t   beats [$];
    feed_beat_t   beat;
    unique case (cmd)
      sfm_pkg::CMD_POST: begin
        if (stamp_counter != '1) stamp_counter = stamp_counter + 1;
        ring_ids[u][ring_next[u]] = id;
        ring_stamps[u][ring_next[u]] = stamp_counter;
        ring_next[u] = (ring_next[u] + 1) % KEEP_PER_USER;
        if (ring_fill[u] < KEEP_PER_USER) ring_fill[u]++;
      end
      sfm_pkg::CMD_FOLLOW: follow_rows[u][peer] = 1'b1;
      sfm_pkg::CMD_UNFOLLOW: follow_rows[u][peer] = 1'b0;
      default: begin
        for (int k = 0; k < NUM_USERS; k++) taken[k] = 0;
        count = 0;
        found = 1'b1;
        while (count < FEED_LENGTH && found) begin
          found = 1'b0;
          best = 0;
          best_stamp = '0;
          for (int k = 0; k < NUM_USERS; k++) begin
            if ((k == u || follow_rows[u][k]) && taken[k] < ring_fill[k]) begin
              slot = (ring_next[k] + KEEP_PER_USER - 1 - taken[k]) % KEEP_PER_USER;
              s = ring_stamps[k][slot];
              if (!found || s > best_stamp) begin
                found = 1'b1;
                best = k;
                best_stamp = s;
              end
            end
          end
          if (found) begin
            slot = (ring_next[best] + KEEP_PER_USER - 1 - taken[best]) % KEEP_PER_USER;
            beat.tweet = ring_ids[best][slot];
            beat.last = 1'b0;
            beat.empty = 1'b0;
            beats = {beats, beat};
            taken[best]++;
            count++;
          end
        end
        if (beats.size() == 0) begin
          beat.tweet = '0;
          beat.last = 1'b1;
          beat.empty = 1'b1;
          beats = {beats, beat};
        end
        beats[beats.size() - 1].last = 1'b1;
        if (record)
          foreach (beats[k]) feed_expected = {feed_expected, beats[k]};
      end
    endcase
  endtask

  // Offer one command beat and hold it until the unit takes it.
  task automatic send_command(input sfm_pkg::cmd_t cmd, input logic [USER_W-1:0] u,
                              input logic [USER_W-1:0] peer, input logic [ID_W-1:0] id);
    in_valid <= 1'b1;
    command <= cmd;
    user <= u;
    other_user <= peer;
    tweet_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid for a burst of idle cycles on the command side.
  task automatic sender_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Half the traffic goes to a few busy users so rings wrap and follows overlap.
  function automatic logic [USER_W-1:0] pick_user();
    if ($urandom_range(0, 1) == 0) return USER_W'($urandom_range(0, 3));
    return USER_W'($urandom_range(0, NUM_USERS - 1));
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_done && hold_left == 0) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 1) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      out_ready <= 1'b1;
      hold_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    feed_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (feed_expected.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'd0, {16'd0, feed_tweet});
      end else begin
        want = feed_expected.pop_front();
        if (feed_tweet !== want.tweet)
          report_mismatch("feed_tweet", {16'd0, want.tweet}, {16'd0, feed_tweet});
        if (last !== want.last)
          report_mismatch("last", {31'd0, want.last}, {31'd0, last});
        if (empty_res !== want.empty)
          report_mismatch("empty_res", {31'd0, want.empty}, {31'd0, empty_res});
      end
    end
  end

  // Count cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int                kind;
    int                forced_feeds;
    sfm_pkg::cmd_t     cmd;
    logic [USER_W-1:0] u;
    logic [USER_W-1:0] peer;
    logic [ID_W-1:0]   id;
    feed_beat_t        typed_beat;

    clear_tables();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script: typed rows carry their answer, the rest go to the mirror.
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      send_command(SCRIPT[r].cmd, SCRIPT[r].user, SCRIPT[r].peer, SCRIPT[r].tweet);
      apply_command(SCRIPT[r].cmd, SCRIPT[r].user, SCRIPT[r].peer, SCRIPT[r].tweet,
                    !SCRIPT[r].typed);
      if (SCRIPT[r].typed) begin
        typed_beat.tweet = SCRIPT[r].want_tweet;
        typed_beat.last = SCRIPT[r].want_last;
        typed_beat.empty = SCRIPT[r].want_empty;
        feed_expected = {feed_expected, typed_beat};
      end
      if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 10));
    end

    // Random commands; one stretch of feeds lands on a long receiver hold-off.
    forced_feeds = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        hold_armed <= 1'b1;
        forced_feeds = 5;
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      kind = (forced_feeds > 0) ? 99 : $urandom_range(0, 99);
      if (forced_feeds > 0) forced_feeds--;
      u = pick_user();
      peer = pick_user();
      id = ID_W'($urandom);
      if (kind < 45) cmd = sfm_pkg::CMD_POST;
      else if (kind < 60) cmd = sfm_pkg::CMD_FOLLOW;
      else if (kind < 70) cmd = sfm_pkg::CMD_UNFOLLOW;
      else cmd = sfm_pkg::CMD_FEED;
      send_command(cmd, u, peer, id);
      apply_command(cmd, u, peer, id, 1'b1);
      if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
        sender_gap($urandom_range(1, 10));
    end
    in_valid <= 1'b0;

    // Drain the outstanding beats, then give the unit time to show strays.
    while (feed_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (feed_expected.size() != 0)
      report_mismatch("expected beats never arrived", 32'd0, feed_expected.size());
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
sv/sfm_pkg.sv
sv/sfm_ram.sv
sv/subscription_feed_merge_unit.sv
sim/tb_top.sv
